>>> rtl/etd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etd_pkg: shared types and constants of the telemetry deframer
// Packet geometry, status codes, register indexes, scaling constants and
// the bytewise CRC-8 step used by the deframer.
// ----------------------------------------------------------------------------
package etd_pkg;

  localparam int PACKET_BYTES = 10;
  localparam int DATA_BYTES   = PACKET_BYTES - 1;
  localparam int COUNT_W      = $clog2(PACKET_BYTES);
  localparam int IDX_W        = $clog2(DATA_BYTES);

  // Result status codes
  localparam logic [1:0] STATUS_SENT    = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
  localparam logic [1:0] STATUS_LIMITED = 2'd2;

  // Input action codes
  localparam logic ACTION_BYTE = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_GAP     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL = 1'd1;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] RESET_GAP_DEFAULT     = 16'd5;
  localparam logic [15:0] SEND_INTERVAL_DEFAULT = 16'd100;
  localparam logic [15:0] MS_SAT                = 16'hFFFF;

  localparam logic [7:0] CRC_POLY = 8'h07;

  // x / 10 for any 16-bit x equals (x * 52429) >> 19
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;
  localparam logic [6:0]  RPM_SCALE   = 7'd100;
  localparam logic [3:0]  TEMP_SCALE  = 4'd10;

  localparam int TENTHS_W = 13;
  localparam int CAP_W    = 16;
  localparam int RPM_W    = 23;
  localparam int TEMP_W   = 12;

  typedef logic [7:0] byte_t;

  // One CRC-8 step over a whole byte, MSB first, no reflection
  function automatic byte_t crc8_step(byte_t crc, byte_t data);
    byte_t c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/etd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etd_if: valid/ready channels of the telemetry deframer
// Input channel carries bytes and millisecond ticks, output channel carries
// one decoded telemetry word per completed packet.
// ----------------------------------------------------------------------------
interface etd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_value;

  modport source (output valid, output action, output byte_value, input ready);
  modport sink   (input valid, input action, input byte_value, output ready);
endinterface

interface etd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [12:0] voltage_tenths;
  logic [12:0] current_tenths;
  logic [15:0] capacity_used;
  logic [22:0] rpm_value;
  logic [11:0] temperature_tenths;

  modport source (output valid, output status, output voltage_tenths,
                  output current_tenths, output capacity_used, output rpm_value,
                  output temperature_tenths, input ready);
  modport sink   (input valid, input status, input voltage_tenths,
                  input current_tenths, input capacity_used, input rpm_value,
                  input temperature_tenths, output ready);
endinterface
`default_nettype wire

>>> rtl/esc_telemetry_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// esc_telemetry_deframer: motor controller telemetry packet deframer
// Assembles 10-byte telemetry packets from a serial byte stream, checks the
// CRC-8 and silence gaps, rate-limits sends and scales the packet fields.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one word per cycle while ready; action 0 = serial byte, 1 = ms tick.
//   out_ch : one word per completed packet (status plus scaled fields).
//   cfg_*  : write reset_gap_ms (index 0) and send_interval_ms (index 1)
//            while the block is idle.
// Throughput is one input word per cycle while in_ch.ready is high; bytes and
// ticks never wait on each other. The final (CRC) byte passes through the
// packet-capture register and then the output register, which is loaded from
// the scaling stage whose constant multipliers (divide by ten, times one
// hundred, times ten) set the critical path.
// Reset (synchronous, rst_n low) clears the byte counter, CRC, both timers
// and the seen flags, and loads the register defaults 5 and 100. Packet byte
// storage is not cleared.
// When the receiver stalls, the output word holds and one more finished
// packet can wait in the capture register; in_ch.ready drops only while that
// register is full and cannot advance.
// ----------------------------------------------------------------------------
module esc_telemetry_deframer
  import etd_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  etd_in_if.sink                in_ch,
  etd_out_if.source             out_ch,
  input  wire                   cfg_we,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration
  logic [15:0] reset_gap_r;
  logic [15:0] send_interval_r;

  // Assembly state
  byte_t              packet_bytes_r [DATA_BYTES];
  logic [COUNT_W-1:0] byte_count_r;
  byte_t              running_crc_r;
  logic [15:0]        ms_since_byte_r;
  logic               byte_seen_r;
  logic [15:0]        ms_since_send_r;
  logic               send_seen_r;

  // Capture stage: raw fields of a finished packet
  logic        s1_valid_r;
  logic [1:0]  s1_status_r;
  logic [15:0] s1_volt_r;
  logic [15:0] s1_curr_r;
  logic [15:0] s1_cap_r;
  logic [15:0] s1_rpm_r;
  byte_t       s1_temp_r;

  // Output register
  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [TENTHS_W-1:0] out_volt_r;
  logic [TENTHS_W-1:0] out_curr_r;
  logic [CAP_W-1:0]    out_cap_r;
  logic [RPM_W-1:0]    out_rpm_r;
  logic [TEMP_W-1:0]   out_temp_r;

  logic               out_free;
  logic               s1_advance;
  logic               in_accept;
  logic               is_byte;
  logic               is_tick;
  logic               gap_restart;
  logic [COUNT_W-1:0] count_eff;
  byte_t              crc_eff;
  logic               is_final;
  logic               crc_ok;
  logic               rate_limited;

  // Advance the capture stage whenever the output register is empty or taken
  assign out_free   = !out_valid_r || out_ch.ready;
  assign s1_advance = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_accept  = in_ch.valid && in_ch.ready;
  assign is_byte    = in_accept && (in_ch.action == ACTION_BYTE);
  assign is_tick    = in_accept && (in_ch.action == ACTION_TICK);

  // A long enough silence before a byte restarts the packet
  assign gap_restart  = byte_seen_r && (ms_since_byte_r >= reset_gap_r);
  assign count_eff    = gap_restart ? '0 : byte_count_r;
  assign crc_eff      = gap_restart ? '0 : running_crc_r;
  assign is_final     = (count_eff == COUNT_W'(DATA_BYTES));
  assign crc_ok       = (in_ch.byte_value == crc_eff);
  assign rate_limited = send_seen_r && (ms_since_send_r < send_interval_r);

  // Configuration writes; indexes beyond the list fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_gap_r     <= RESET_GAP_DEFAULT;
      send_interval_r <= SEND_INTERVAL_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESET_GAP:     reset_gap_r     <= cfg_wdata;
        CFG_SEND_INTERVAL: send_interval_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Packet byte storage: written in order, read at fixed places, no reset
  always_ff @(posedge clk) begin
    if (is_byte && !is_final) begin
      packet_bytes_r[count_eff[IDX_W-1:0]] <= in_ch.byte_value;
    end
  end

  // Counters, CRC, timers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r    <= '0;
      running_crc_r   <= '0;
      ms_since_byte_r <= '0;
      byte_seen_r     <= 1'b0;
      ms_since_send_r <= '0;
      send_seen_r     <= 1'b0;
    end else if (is_tick) begin
      // Saturate both timers at full scale
      if (ms_since_byte_r != MS_SAT) ms_since_byte_r <= ms_since_byte_r + 16'd1;
      if (ms_since_send_r != MS_SAT) ms_since_send_r <= ms_since_send_r + 16'd1;
    end else if (is_byte) begin
      byte_seen_r     <= 1'b1;
      ms_since_byte_r <= '0;
      if (is_final) begin
        byte_count_r  <= '0;
        running_crc_r <= '0;
        // Only a sent packet restarts the send timer
        if (crc_ok && !rate_limited) begin
          send_seen_r     <= 1'b1;
          ms_since_send_r <= '0;
        end
      end else begin
        byte_count_r  <= count_eff + COUNT_W'(1);
        running_crc_r <= crc8_step(crc_eff, in_ch.byte_value);
      end
    end
  end

  // Capture stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (is_byte && is_final) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Capture stage payload: zero the fields of a CRC failure
  always_ff @(posedge clk) begin
    if (is_byte && is_final) begin
      if (!crc_ok) begin
        s1_status_r <= STATUS_CRC_ERR;
        s1_volt_r   <= '0;
        s1_curr_r   <= '0;
        s1_cap_r    <= '0;
        s1_rpm_r    <= '0;
        s1_temp_r   <= '0;
      end else begin
        s1_status_r <= rate_limited ? STATUS_LIMITED : STATUS_SENT;
        s1_volt_r   <= {packet_bytes_r[1], packet_bytes_r[2]};
        s1_curr_r   <= {packet_bytes_r[3], packet_bytes_r[4]};
        s1_cap_r    <= {packet_bytes_r[5], packet_bytes_r[6]};
        s1_rpm_r    <= {packet_bytes_r[7], packet_bytes_r[8]};
        s1_temp_r   <= packet_bytes_r[0];
      end
    end
  end

  // Scaling: constant multipliers only
  logic [31:0]        volt_prod;
  logic [31:0]        curr_prod;
  logic [RPM_W-1:0]   rpm_prod;
  logic [TEMP_W-1:0]  temp_prod;

  assign volt_prod = 32'(s1_volt_r) * 32'(DIV10_MUL);
  assign curr_prod = 32'(s1_curr_r) * 32'(DIV10_MUL);
  assign rpm_prod  = RPM_W'(s1_rpm_r) * RPM_W'(RPM_SCALE);
  assign temp_prod = TEMP_W'(s1_temp_r) * TEMP_W'(TEMP_SCALE);

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_status_r <= s1_status_r;
      out_volt_r   <= volt_prod[DIV10_SHIFT +: TENTHS_W];
      out_curr_r   <= curr_prod[DIV10_SHIFT +: TENTHS_W];
      out_cap_r    <= s1_cap_r;
      out_rpm_r    <= rpm_prod;
      out_temp_r   <= temp_prod;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = out_status_r;
  assign out_ch.voltage_tenths     = out_volt_r;
  assign out_ch.current_tenths     = out_curr_r;
  assign out_ch.capacity_used      = out_cap_r;
  assign out_ch.rpm_value          = out_rpm_r;
  assign out_ch.temperature_tenths = out_temp_r;

  // Assertions
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= COUNT_W'(DATA_BYTES))
    else $error("byte counter beyond data bytes");

  a_final_captured: assert property (@(posedge clk) disable iff (!rst_n)
    (is_byte && is_final) |=> s1_valid_r)
    else $error("final byte did not load capture stage");

  a_crc_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STATUS_CRC_ERR) |->
      (out_volt_r == '0 && out_curr_r == '0 && out_cap_r == '0 &&
       out_rpm_r == '0 && out_temp_r == '0))
    else $error("CRC error word carries nonzero fields");

  a_sent_restarts_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (is_byte && is_final && crc_ok && !rate_limited) |=>
      (ms_since_send_r == '0 && send_seen_r))
    else $error("sent packet did not restart send timer");

endmodule
`default_nettype wire
